// ===== design/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
// No dependencies; used by rgb_to_hsl_convert and rhc_check.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    localparam int CH_W      = 8;    // one color channel
    localparam int LSUM_W    = 9;    // max + min
    localparam int LSUM_MAX  = 510;
    localparam int DEN_HALF  = 255;  // above this the saturation divisor folds
    localparam int HUE_MUL   = 60;   // degrees per unit of diff/delta
    localparam int HUE_DEG_W = 9;    // integer degree bits of hue

    // Channel that holds the maximum; ties go red, then green, then blue.
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_max_sel;

endpackage

`default_nettype wire

// ===== design/rgb_to_hsl_convert.sv =====
// RGB to HSL converter top level: max/min stage, setup stage, two parallel
// restoring dividers unrolled one quotient bit per stage, output register.
// Depends on rhc_pkg.
// Throughput: one item per clock while the output is not stalled, with no dead cycles between items.
// Pipeline: L + 3 register stages, L = max(14 + HUE_FRAC_BITS, 8 + SAT_BITS)
//   the divider depth (24 at defaults).
// The divider depth is set by the wider of the hue and saturation quotients.
// Backpressure: per-stage ready, so bubbles are squeezed out during a stall.
// Reset: i_rst_n synchronous, active low; clears all stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_convert #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_BITS      = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // Input item: red [7:0], green [15:8], blue [23:16]
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire logic [3*rhc_pkg::CH_W-1:0] i_s_axis_tdata,
    // Result item: hue, saturation, lightness_sum from bit 0 up, zero padded
    output logic o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    output logic [((9 + HUE_FRAC_BITS + SAT_BITS + rhc_pkg::LSUM_W + 7) / 8) * 8 - 1:0]
                 o_m_axis_tdata
);

    localparam int CW     = rhc_pkg::CH_W;
    localparam int HUE_W  = rhc_pkg::HUE_DEG_W + HUE_FRAC_BITS;
    localparam int NUM_W  = 14;                        // diff * 60 fits 14 bits
    localparam int HDIV_W = NUM_W + HUE_FRAC_BITS;
    localparam int SDIV_W = CW + SAT_BITS;
    localparam int L      = (HDIV_W > SDIV_W) ? HDIV_W : SDIV_W;
    localparam int NS     = L + 3;                     // total register stages
    localparam int RAW_W  = HUE_W + SAT_BITS + rhc_pkg::LSUM_W;
    localparam int OUT_W  = ((RAW_W + 7) / 8) * 8;

    localparam logic [HUE_W-1:0] OFF120 = HUE_W'(120 * (1 << HUE_FRAC_BITS));
    localparam logic [HUE_W-1:0] OFF240 = HUE_W'(240 * (1 << HUE_FRAC_BITS));
    localparam logic [HUE_W-1:0] OFF360 = HUE_W'(360 * (1 << HUE_FRAC_BITS));
    localparam logic [SAT_BITS-1:0] SAT_MAX = {SAT_BITS{1'b1}};

    // ---------------------------------------------------------------
    // Stage valid bits and ready chain. Stage 0: max/min, stage 1: setup
    // (divider slot 0), stages 2..L+1: divider steps, stage L+2: output.
    // ---------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;

    assign w_rdy[NS-1] = !r_v[NS-1] || i_m_axis_tready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_v[NS-1];

    // ---------------------------------------------------------------
    // Stage 0: max, min and which channel won
    // ---------------------------------------------------------------
    logic [CW-1:0] w_red, w_green, w_blue;
    logic [CW-1:0] n_max, n_min;
    rhc_pkg::t_max_sel n_sel;

    logic [CW-1:0] r_a_red, r_a_green, r_a_blue, r_a_max, r_a_min;
    rhc_pkg::t_max_sel r_a_sel;

    assign w_red   = i_s_axis_tdata[CW-1:0];
    assign w_green = i_s_axis_tdata[2*CW-1:CW];
    assign w_blue  = i_s_axis_tdata[3*CW-1:2*CW];

    always_comb begin
        if (w_red >= w_green && w_red >= w_blue) begin
            n_sel = rhc_pkg::SEL_RED;
            n_max = w_red;
        end else if (w_green >= w_blue) begin
            n_sel = rhc_pkg::SEL_GREEN;
            n_max = w_green;
        end else begin
            n_sel = rhc_pkg::SEL_BLUE;
            n_max = w_blue;
        end
        n_min = w_red;
        if (w_green < n_min) n_min = w_green;
        if (w_blue < n_min)  n_min = w_blue;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_a_red   <= w_red;
            r_a_green <= w_green;
            r_a_blue  <= w_blue;
            r_a_max   <= n_max;
            r_a_min   <= n_min;
            r_a_sel   <= n_sel;
        end
    end

    // ---------------------------------------------------------------
    // Divider pipeline arrays; index 0 is loaded by the setup stage.
    // hw/sw: dividend shifting out, quotient shifting in.
    // hr/sr: partial remainders. dl: delta (hue divisor), dn: sat divisor.
    // ---------------------------------------------------------------
    logic [L-1:0]              r_hw  [0:L];
    logic [L-1:0]              r_sw  [0:L];
    logic [CW-1:0]             r_hr  [0:L];
    logic [CW-1:0]             r_sr  [0:L];
    logic [CW-1:0]             r_dl  [0:L];
    logic [CW-1:0]             r_dn  [0:L];
    logic                      r_neg [0:L];
    rhc_pkg::t_max_sel         r_sel [0:L];
    logic [rhc_pkg::LSUM_W-1:0] r_sum [0:L];

    // ---------------------------------------------------------------
    // Stage 1: delta, sum, folded divisor, hue numerator |diff| * 60
    // ---------------------------------------------------------------
    logic [CW-1:0]              n_delta, n_den, n_pa, n_pb, n_mag;
    logic [rhc_pkg::LSUM_W-1:0] n_sum;
    logic                       n_neg;
    logic [NUM_W-1:0]           n_num;

    always_comb begin
        n_delta = r_a_max - r_a_min;
        n_sum   = {1'b0, r_a_max} + {1'b0, r_a_min};
        if (n_sum > rhc_pkg::LSUM_W'(rhc_pkg::DEN_HALF)) begin
            n_den = CW'(rhc_pkg::LSUM_W'(rhc_pkg::LSUM_MAX) - n_sum);
        end else begin
            n_den = n_sum[CW-1:0];
        end
        unique case (r_a_sel)
            rhc_pkg::SEL_RED: begin
                n_pa = r_a_green;
                n_pb = r_a_blue;
            end
            rhc_pkg::SEL_GREEN: begin
                n_pa = r_a_blue;
                n_pb = r_a_red;
            end
            rhc_pkg::SEL_BLUE: begin
                n_pa = r_a_red;
                n_pb = r_a_green;
            end
            default: begin
                n_pa = '0;
                n_pb = '0;
            end
        endcase
        n_neg = n_pa < n_pb;
        n_mag = n_neg ? (n_pb - n_pa) : (n_pa - n_pb);
        // 60 * mag = 64 * mag - 4 * mag
        n_num = NUM_W'({n_mag, 6'b0}) - NUM_W'({n_mag, 2'b0});
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_hw[0]  <= L'(n_num) << HUE_FRAC_BITS;
            r_sw[0]  <= L'(n_delta) << SAT_BITS;
            r_hr[0]  <= '0;
            r_sr[0]  <= '0;
            r_dl[0]  <= n_delta;
            r_dn[0]  <= n_den;
            r_neg[0] <= n_neg;
            r_sel[0] <= r_a_sel;
            r_sum[0] <= n_sum;
        end
    end

    // ---------------------------------------------------------------
    // Divider steps: one restoring step per stage for each quotient.
    // Partial remainders stay below the divisor, so 8 bits suffice.
    // ---------------------------------------------------------------
    for (genvar j = 1; j <= L; j++) begin : g_div
        logic [CW:0]   w_h2, w_s2;
        logic          w_hge, w_sge;
        logic [CW-1:0] w_hrem, w_srem;

        assign w_h2   = {r_hr[j-1], r_hw[j-1][L-1]};
        assign w_s2   = {r_sr[j-1], r_sw[j-1][L-1]};
        assign w_hge  = w_h2 >= {1'b0, r_dl[j-1]};
        assign w_sge  = w_s2 >= {1'b0, r_dn[j-1]};
        assign w_hrem = w_hge ? CW'(w_h2 - {1'b0, r_dl[j-1]}) : w_h2[CW-1:0];
        assign w_srem = w_sge ? CW'(w_s2 - {1'b0, r_dn[j-1]}) : w_s2[CW-1:0];

        always_ff @(posedge i_clk) begin
            if (w_rdy[j+1]) begin
                r_hw[j]  <= {r_hw[j-1][L-2:0], w_hge};
                r_sw[j]  <= {r_sw[j-1][L-2:0], w_sge};
                r_hr[j]  <= w_hrem;
                r_sr[j]  <= w_srem;
                r_dl[j]  <= r_dl[j-1];
                r_dn[j]  <= r_dn[j-1];
                r_neg[j] <= r_neg[j-1];
                r_sel[j] <= r_sel[j-1];
                r_sum[j] <= r_sum[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: sign and offset for hue, clamp saturation,
    // force zero for grey pixels.
    // ---------------------------------------------------------------
    logic [HUE_W-1:0]    n_off, n_hue, w_qh;
    logic [SAT_BITS-1:0] n_sat;
    logic                w_grey;

    logic [HUE_W-1:0]            r_out_hue;
    logic [SAT_BITS-1:0]         r_out_sat;
    logic [rhc_pkg::LSUM_W-1:0]  r_out_sum;

    assign w_qh   = r_hw[L][HUE_W-1:0];   // quotient never exceeds 60 degrees
    assign w_grey = (r_dl[L] == '0);

    always_comb begin
        unique case (r_sel[L])
            rhc_pkg::SEL_RED:   n_off = r_neg[L] ? OFF360 : '0;
            rhc_pkg::SEL_GREEN: n_off = OFF120;
            rhc_pkg::SEL_BLUE:  n_off = OFF240;
            default:            n_off = '0;
        endcase
        n_hue = r_neg[L] ? (n_off - w_qh) : (n_off + w_qh);
        // ratio is at most 1; exactly 1 clamps to all ones
        n_sat = r_sw[L][SAT_BITS] ? SAT_MAX : r_sw[L][SAT_BITS-1:0];
        if (w_grey) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS-1]) begin
            r_out_hue <= n_hue;
            r_out_sat <= n_sat;
            r_out_sum <= r_sum[L];
        end
    end

    assign o_m_axis_tdata = OUT_W'({r_out_sum, r_out_sat, r_out_hue});

endmodule

`default_nettype wire

// ===== design/rhc_check.sv =====
// Port-level checker for rgb_to_hsl_convert, with its bind statement.
// Depends on rhc_pkg; watches the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module rhc_check #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_BITS      = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_s_axis_tready,
    input wire logic o_m_axis_tvalid,
    input wire logic i_m_axis_tready,
    input wire logic [((9 + HUE_FRAC_BITS + SAT_BITS + rhc_pkg::LSUM_W + 7) / 8) * 8 - 1:0]
                     o_m_axis_tdata
);

    localparam int HUE_W = rhc_pkg::HUE_DEG_W + HUE_FRAC_BITS;
    localparam int SAT_LO = HUE_W;
    localparam int SUM_LO = HUE_W + SAT_BITS;
    localparam logic [HUE_W-1:0] HUE_LIM = HUE_W'(360 * (1 << HUE_FRAC_BITS));

    logic [HUE_W-1:0]           w_hue;
    logic [SAT_BITS-1:0]        w_sat;
    logic [rhc_pkg::LSUM_W-1:0] w_sum;

    assign w_hue = o_m_axis_tdata[HUE_W-1:0];
    assign w_sat = o_m_axis_tdata[SAT_LO +: SAT_BITS];
    assign w_sum = o_m_axis_tdata[SUM_LO +: rhc_pkg::LSUM_W];

    // A stalled result item holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result item changed while stalled");

    // An empty output stage means the whole pipe can take an item.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("not ready with empty output");

    // Hue stays below 360 degrees; lightness sum stays in range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_hue < HUE_LIM) && (w_sum <= rhc_pkg::LSUM_W'(rhc_pkg::LSUM_MAX)))
        else $error("hue or lightness out of range");

    // Zero saturation only for grey pixels, which also carry zero hue.
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_sat == '0) |-> (w_hue == '0))
        else $error("zero saturation with nonzero hue");

endmodule

bind rgb_to_hsl_convert rhc_check #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_BITS(SAT_BITS)
) u_rhc_check (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata(o_m_axis_tdata)
);

`default_nettype wire
